// File: design/point_in_polygon_test_top_defines.svh
`ifndef POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PIPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PIPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pipt_pkg.sv
`default_nettype none

package pipt_pkg;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_WAITJ = 9'b000000010,
    ST_LOADJ = 9'b000000100,
    ST_DIFF  = 9'b000001000,
    ST_MAG   = 9'b000010000,
    ST_MUL   = 9'b000100000,
    ST_FIN   = 9'b001000000,
    ST_NEXT  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  // Two products, each split into four half-width partial products
  localparam int unsigned MUL_STEPS = 8;
  localparam int unsigned STEP_W    = 3;

  localparam int unsigned COUNT_W = 7;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned FIELD_W = 32;

endpackage

`default_nettype wire

// File: design/point_in_polygon_test_top.sv
// Point-in-polygon test, crossing-number rule on signed fixed-point coordinates.
// Input channel (in_valid_i / in_stall_o): op_i = write stores coord_x_i/coord_y_i
// at vertex_index_i and gives no result; op_i = query tests the point.
// Output channel (out_valid_o / out_stall_i) returns one inside_res_o per query.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) sets vertex_count; write
// it only while the block is idle. cfg_ready_o is always high.
// A query walks every edge once through a single half-width multiplier and one
// accumulator. After setup, an edge whose y span misses the point passes through
// the difference and update steps only; an edge that spans it adds eight partial
// products plus magnitude and drain between them. The result is then handed off;
// with no vertices a query goes straight to the hand-off.
// in_stall_o is high while a query is in flight. A finished result sits in the
// output register, so the next transaction is accepted while it waits; if the
// receiver stalls and a second query finishes, that query holds until the output
// register frees up.
// Reset clears vertex_count to 0 and empties the pipeline; the vertex table is
// not cleared and must be written before it is queried.
`default_nettype none

`include "point_in_polygon_test_top_defines.svh"

module point_in_polygon_test_top #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic [pipt_pkg::SLOT_W-1:0]         vertex_index_i,
  input  logic signed [pipt_pkg::FIELD_W-1:0] coord_x_i,
  input  logic signed [pipt_pkg::FIELD_W-1:0] coord_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                inside_res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pipt_pkg::COUNT_W-1:0]        cfg_data_i
);

  import pipt_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int D     = COORD_WIDTH + 1;  // difference width
  localparam int H     = (D + 1) / 2;      // multiplier operand width
  localparam int PW    = 2 * H;
  localparam int AW    = 4 * H + 1;        // accumulator holds a*b - c*d

  state_e state_q, state_d;

  logic [COUNT_W-1:0] vertex_count_q;
  logic               out_valid_q;
  logic               inside_res_q;
  logic               pv_q;

  logic signed [CW-1:0] mem_x [MAX_VERTICES];
  logic signed [CW-1:0] mem_y [MAX_VERTICES];
  logic signed [CW-1:0] rd_x_q, rd_y_q;

  logic [IDX_W-1:0]     idx_q;
  logic [CNT_W-1:0]     n_q;
  logic                 last_q;
  logic                 inside_q;
  logic signed [CW-1:0] px_q, py_q, xi_q, yi_q, xj_q, yj_q;
  logic signed [D-1:0]  a_q, b_q, c_q, d_q;
  logic                 span_q;
  logic [PW-1:0]        ma_q, mb_q, mc_q, md_q;
  logic                 sab_q, scd_q;
  logic [STEP_W-1:0]    step_q;
  logic [PW-1:0]        pp_q;
  logic [1:0]           pp_sh_q;
  logic                 pp_neg_q;
  logic [AW-1:0]        acc_q;

  logic             in_acc, take;
  logic             wr_en;
  logic [IDX_W-1:0] waddr;
  logic [CNT_W-1:0] n_cfg;
  logic             span;
  logic             left;
  logic [PW-1:0]    op1, op2;
  logic [H-1:0]     ch1, ch2;
  logic [PW-1:0]    pp;
  logic [AW-1:0]    term;
  logic [D-1:0]     neg_a, neg_b, neg_c, neg_d;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_res_q;
  assign take         = !out_valid_q || !out_stall_i;

  assign wr_en = in_acc && (op_i == OP_WRITE) &&
                 (32'(vertex_index_i) < 32'(MAX_VERTICES));
  assign waddr = IDX_W'(vertex_index_i);
  assign n_cfg = (32'(vertex_count_q) > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                            : CNT_W'(vertex_count_q);

  // half-open y test against the edge from vertex j to vertex i
  assign span = ((rd_y_q <= py_q) && (py_q < yj_q)) ||
                ((yj_q <= py_q) && (py_q < rd_y_q));

  // acc = (x-xi)*dy - (xj-xi)*(y-yi); comparison flips with the sign of dy
  assign left = b_q[D-1] ? (!acc_q[AW-1] && (acc_q != '0)) : acc_q[AW-1];

  assign neg_a = D'(0) - a_q;
  assign neg_b = D'(0) - b_q;
  assign neg_c = D'(0) - c_q;
  assign neg_d = D'(0) - d_q;

  // shared multiplier: step[2] picks the product, step[1:0] the halves
  assign op1 = step_q[2] ? mc_q : ma_q;
  assign op2 = step_q[2] ? md_q : mb_q;
  assign ch1 = step_q[1] ? op1[PW-1:H] : op1[H-1:0];
  assign ch2 = step_q[0] ? op2[PW-1:H] : op2[H-1:0];
  assign pp  = PW'(ch1) * PW'(ch2);

  always_comb begin
    unique case (pp_sh_q)
      2'd0:    term = AW'(pp_q);
      2'd1:    term = AW'(pp_q) << H;
      2'd2:    term = AW'(pp_q) << (2 * H);
      default: term = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (op_i == OP_QUERY)) begin
          state_d = (n_cfg == '0) ? ST_DONE : ST_WAITJ;
        end
      end
      ST_WAITJ: state_d = ST_LOADJ;
      ST_LOADJ: state_d = ST_DIFF;
      ST_DIFF:  state_d = span ? ST_MAG : ST_NEXT;
      ST_MAG:   state_d = ST_MUL;
      ST_MUL: begin
        if (step_q == STEP_W'(MUL_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:  state_d = ST_NEXT;
      ST_NEXT: state_d = last_q ? ST_DONE : ST_DIFF;
      ST_DONE: begin
        if (take) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      vertex_count_q <= '0;
      out_valid_q    <= 1'b0;
      pv_q           <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= (state_q == ST_MUL);
      if (cfg_valid_i && cfg_ready_o) begin
        vertex_count_q <= cfg_data_i;
      end
      if ((state_q == ST_DONE) && take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // vertex table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[waddr] <= CW'(coord_x_i);
      mem_y[waddr] <= CW'(coord_y_i);
    end
    rd_x_q <= mem_x[idx_q];
    rd_y_q <= mem_y[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (pv_q) begin
      acc_q <= acc_q + (term ^ {AW{pp_neg_q}}) + AW'(pp_neg_q);
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (op_i == OP_QUERY)) begin
          px_q     <= CW'(coord_x_i);
          py_q     <= CW'(coord_y_i);
          n_q      <= n_cfg;
          idx_q    <= IDX_W'(n_cfg - CNT_W'(1));
          inside_q <= 1'b0;
        end
      end
      ST_WAITJ: idx_q <= '0;
      ST_LOADJ: begin
        xj_q <= rd_x_q;
        yj_q <= rd_y_q;
      end
      ST_DIFF: begin
        xi_q   <= rd_x_q;
        yi_q   <= rd_y_q;
        a_q    <= D'(px_q) - D'(rd_x_q);
        b_q    <= D'(yj_q) - D'(rd_y_q);
        c_q    <= D'(xj_q) - D'(rd_x_q);
        d_q    <= D'(py_q) - D'(rd_y_q);
        span_q <= span;
        last_q <= (idx_q == IDX_W'(n_q - CNT_W'(1)));
        // advance early so the next vertex is read while this edge runs
        if (idx_q != IDX_W'(n_q - CNT_W'(1))) begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end
      ST_MAG: begin
        ma_q   <= PW'(a_q[D-1] ? neg_a : a_q);
        mb_q   <= PW'(b_q[D-1] ? neg_b : b_q);
        mc_q   <= PW'(c_q[D-1] ? neg_c : c_q);
        md_q   <= PW'(d_q[D-1] ? neg_d : d_q);
        sab_q  <= a_q[D-1] ^ b_q[D-1];
        scd_q  <= c_q[D-1] ^ d_q[D-1];
        acc_q  <= '0;
        step_q <= '0;
      end
      ST_MUL: begin
        step_q   <= step_q + STEP_W'(1);
        pp_q     <= pp;
        pp_sh_q  <= 2'(step_q[1]) + 2'(step_q[0]);
        pp_neg_q <= step_q[2] ? !scd_q : sab_q;
      end
      ST_FIN: ;
      ST_NEXT: begin
        if (span_q && left) begin
          inside_q <= !inside_q;
        end
        xj_q <= xi_q;
        yj_q <= yi_q;
      end
      ST_DONE: begin
        if (take) begin
          inside_res_q <= inside_q;
        end
      end
      default: ;
    endcase
  end

  `PIPT_ASSERT_NEXT(a_result_loaded, (state_q == ST_DONE) && take, out_valid_q && (inside_res_q == $past(inside_q)), "result not loaded on hand-off")
  `PIPT_ASSERT_NOW(a_idx_in_range, (state_q == ST_DIFF), (CNT_W'(idx_q) < n_q), "edge walk ran past vertex count")
  `PIPT_ASSERT_NEXT(a_empty_outside, in_acc && (op_i == OP_QUERY) && (n_cfg == '0), (state_q == ST_DONE) && !inside_q, "empty polygon must give outside")
  `PIPT_ASSERT_NOW(a_mul_needs_span, (state_q == ST_MUL) || (state_q == ST_FIN), span_q, "multiplier run on an edge that does not span")

endmodule

`default_nettype wire

// File: dv/pipt_crossing_checker.sv
`default_nettype none

module pipt_crossing_checker #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                op_i,
  input  logic [pipt_pkg::SLOT_W-1:0]         vertex_index_i,
  input  logic signed [pipt_pkg::FIELD_W-1:0] coord_x_i,
  input  logic signed [pipt_pkg::FIELD_W-1:0] coord_y_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic                                inside_res_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [pipt_pkg::COUNT_W-1:0]        cfg_data_i,
  output int                                  fail_cnt_o,
  output int                                  pending_cnt_o
);
  import pipt_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               in_poly;
  } query_exp_t;

  int                 vtx_x [MAX_VERTICES];
  int                 vtx_y [MAX_VERTICES];
  logic [COUNT_W-1:0] vertex_count;
  query_exp_t         inside_exp_q [$];
  query_exp_t         head;
  query_exp_t         fresh;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_cnt_o++;
  endtask

  // Crossing parity over all edges, slope test done by exact cross-multiplication
  function automatic logic crossing_parity(int px, int py);
    int unsigned        n;
    int unsigned        i;
    int unsigned        j;
    logic               parity;
    logic               left;
    longint             dx, dy, ex, ey;
    logic signed [127:0] a, b, c, d, lhs, rhs;
    n = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
    parity = 1'b0;
    if (n == 0) return 1'b0;
    j = n - 1;
    for (i = 0; i < n; i++) begin
      if ((vtx_y[i] <= py && py < vtx_y[j]) || (vtx_y[j] <= py && py < vtx_y[i])) begin
        dx  = longint'(px) - longint'(vtx_x[i]);
        dy  = longint'(vtx_y[j]) - longint'(vtx_y[i]);
        ex  = longint'(vtx_x[j]) - longint'(vtx_x[i]);
        ey  = longint'(py) - longint'(vtx_y[i]);
        a   = dx;
        b   = dy;
        c   = ex;
        d   = ey;
        lhs = a * b;
        rhs = c * d;
        left = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
        parity ^= left;
      end
      j = i;
    end
    return parity;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (inside_exp_q.size() == 0) begin
          report_mismatch($sformatf("result %b with no query outstanding", inside_res_i));
        end else begin
          head = inside_exp_q.pop_front();
          if (inside_res_i !== head.in_poly)
            report_mismatch($sformatf("point (%0d,%0d): inside %b, expected %b",
                                      head.x, head.y, inside_res_i, head.in_poly));
        end
      end
      if (cfg_valid_i && cfg_ready_i) vertex_count = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_WRITE) begin
          vtx_x[vertex_index_i] = coord_x_i;
          vtx_y[vertex_index_i] = coord_y_i;
        end else begin
          fresh.x       = coord_x_i;
          fresh.y       = coord_y_i;
          fresh.in_poly = crossing_parity(coord_x_i, coord_y_i);
          inside_exp_q.push_back(fresh);
        end
      end
    end else begin
      vertex_count = '0;
    end
    pending_cnt_o = inside_exp_q.size();
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none

module tb_top;
  import pipt_pkg::*;

  localparam int NUM_ITEMS = 1450;
  localparam int NUM_SLOTS = 64;
  localparam int DRAIN_CYC = 50;
  localparam int IDLE_CYC  = 20;
  localparam int C_MIN     = 32'sh8000_0000;
  localparam int C_MAX     = 32'sh7fff_ffff;

  typedef enum int unsigned {
    SC_TINY,
    SC_MID,
    SC_FULL,
    SC_EDGE
  } coord_scale_e;

  logic                      clk;
  logic                      rst_n       = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic                      in_op       = OP_WRITE;
  logic [SLOT_W-1:0]         in_slot     = '0;
  logic signed [FIELD_W-1:0] in_x        = '0;
  logic signed [FIELD_W-1:0] in_y        = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic                      inside_res;
  logic                      cfg_valid   = 1'b0;
  logic                      cfg_ready;
  logic [COUNT_W-1:0]        cfg_data    = '0;
  int                        fails;
  int                        pending;
  int unsigned               burst_left  = 0;
  int unsigned               items_sent  = 0;

  point_in_polygon_test_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (in_op),
    .vertex_index_i (in_slot),
    .coord_x_i      (in_x),
    .coord_y_i      (in_y),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .inside_res_o   (inside_res),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  pipt_crossing_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .op_i           (in_op),
    .vertex_index_i (in_slot),
    .coord_x_i      (in_x),
    .coord_y_i      (in_y),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .inside_res_i   (inside_res),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .fail_cnt_o     (fails),
    .pending_cnt_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Receiver: free-running, random stall, and now and then a long hold-off
  initial begin : rx_stall
    int unsigned mode;
    int unsigned span;
    int unsigned k;
    mode = 0;
    wait (rst_n);
    repeat (300) @(posedge clk);
    forever begin
      span = (mode == 11) ? $urandom_range(300, 500) : $urandom_range(5, 80);
      for (k = 0; k < span; k++) begin
        if (mode <= 4)
          out_stall <= 1'b0;
        else if (mode == 11)
          out_stall <= 1'b1;
        else
          out_stall <= ($urandom_range(0, 3) != 0);
        @(posedge clk);
      end
      mode = $urandom_range(0, 11);
    end
  end

  task automatic send_item(op_e op, logic [SLOT_W-1:0] slot, int x, int y);
    logic taken;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op    <= op;
    in_slot  <= slot;
    in_x     <= x;
    in_y     <= y;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Register write only once the block has drained
  task automatic set_vertex_count(logic [COUNT_W-1:0] cnt);
    logic taken;
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    repeat (IDLE_CYC) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cnt;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic int rand_coord(coord_scale_e scale);
    case (scale)
      SC_TINY: return int'($urandom_range(0, 16)) - 8;
      SC_MID:  return int'($urandom_range(0, 2000)) - 1000;
      SC_FULL: return int'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return C_MIN;
          1:       return C_MAX;
          2:       return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // Write a polygon into slots 0..n-1, then a mix of queries and stray writes
  task automatic run_polygon(logic [COUNT_W-1:0] cnt);
    int unsigned  nverts;
    int unsigned  nq;
    int unsigned  rot;
    int unsigned  k;
    int unsigned  s;
    int unsigned  r;
    int           qx;
    int           qy;
    int           px [NUM_SLOTS];
    int           py [NUM_SLOTS];
    coord_scale_e scale;
    nverts = (cnt > NUM_SLOTS) ? NUM_SLOTS : cnt;
    nq     = (nverts >= 32) ? 8 : $urandom_range(10, 30);
    scale  = coord_scale_e'($urandom_range(0, 3));
    rot    = $urandom_range(0, 63);
    set_vertex_count(cnt);
    for (k = 0; k < nverts; k++) begin
      s = (k + rot) % nverts;
      px[s] = rand_coord(scale);
      py[s] = rand_coord(scale);
      send_item(OP_WRITE, s[SLOT_W-1:0], px[s], py[s]);
    end
    for (k = 0; k < nq; k++) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        s = $urandom_range(0, NUM_SLOTS - 1);
        qx = rand_coord(coord_scale_e'($urandom_range(0, 3)));
        qy = rand_coord(coord_scale_e'($urandom_range(0, 3)));
        if (s < nverts) begin
          px[s] = qx;
          py[s] = qy;
        end
        send_item(OP_WRITE, s[SLOT_W-1:0], qx, qy);
      end else begin
        r = $urandom_range(0, 8);
        if (r <= 3 && nverts > 0) begin
          // land on vertex coordinates to hit the half-open boundaries
          qx = (r[0]) ? px[$urandom_range(0, nverts - 1)] : rand_coord(scale);
          qy = py[$urandom_range(0, nverts - 1)];
        end else if (r <= 6) begin
          qx = rand_coord(scale);
          qy = rand_coord(scale);
        end else begin
          qx = rand_coord((r == 7) ? SC_FULL : SC_EDGE);
          qy = rand_coord((r == 7) ? SC_FULL : SC_EDGE);
        end
        send_item(OP_QUERY, SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), qx, qy);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty polygon
    set_vertex_count(0);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 6'h3f, C_MIN, C_MIN);
    send_item(OP_QUERY, 0, C_MAX, C_MAX);

    // full-range square, worst-case products
    send_item(OP_WRITE, 0, C_MIN, C_MIN);
    send_item(OP_WRITE, 1, C_MAX, C_MIN);
    send_item(OP_WRITE, 2, C_MAX, C_MAX);
    send_item(OP_WRITE, 3, C_MIN, C_MAX);
    send_item(OP_WRITE, 6'h3f, C_MAX, C_MIN);
    set_vertex_count(4);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 0, C_MIN, C_MIN);
    send_item(OP_QUERY, 0, 0, C_MAX);
    send_item(OP_QUERY, 0, C_MAX, 0);
    send_item(OP_QUERY, 0, C_MIN, 0);
    send_item(OP_QUERY, 0, -1, C_MIN);

    // triangle with a horizontal base
    send_item(OP_WRITE, 0, 0, 0);
    send_item(OP_WRITE, 1, 100, 0);
    send_item(OP_WRITE, 2, 50, 100);
    set_vertex_count(3);
    send_item(OP_QUERY, 0, 50, 0);
    send_item(OP_QUERY, 0, 50, 50);
    send_item(OP_QUERY, 0, 50, 100);
    send_item(OP_QUERY, 0, -1, 50);

    // degenerate, full table and oversized count first, then random polygons
    run_polygon(1);
    run_polygon(2);
    run_polygon(64);
    run_polygon(127);
    while (items_sent < NUM_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r == 0)
        run_polygon(0);
      else if (r == 1)
        run_polygon(COUNT_W'($urandom_range(64, 127)));
      else if (r <= 3)
        run_polygon(COUNT_W'($urandom_range(11, 40)));
      else
        run_polygon(COUNT_W'($urandom_range(3, 10)));
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fails == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+design
design/pipt_pkg.sv
design/point_in_polygon_test_top.sv
dv/pipt_crossing_checker.sv
dv/tb_top.sv
